// File: rtl/threshold_shortest_queue_dispatcher_unit_defines.svh
// assertion macros shared by the dispatcher rtl
`ifndef THRESHOLD_SHORTEST_QUEUE_DISPATCHER_UNIT_DEFINES_SVH
`define THRESHOLD_SHORTEST_QUEUE_DISPATCHER_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define THSQD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define THSQD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/thsqd_pkg.sv
`default_nettype none

package thsqd_pkg;

    // default sizing
    localparam int NUM_WORKERS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // fixed field widths
    localparam int THR_W    = 5;
    localparam int ACTIVE_W = 4;
    localparam int JOB_W    = 16;
    localparam int WSEL_W   = 3;
    localparam int STATUS_W = 2;
    localparam int PEND_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // register reset values
    localparam logic [THR_W-1:0]    THRESHOLD_RST = 5'd2;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST    = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 1'b1;

    // operation codes
    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TAKEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

// File: rtl/thsqd_ram.sv
`default_nettype none

module thsqd_ram #(
    parameter int WIDTH = thsqd_pkg::JOB_W,
    parameter int DEPTH = thsqd_pkg::NUM_WORKERS_DEF * thsqd_pkg::QUEUE_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/thsqd_pick.sv
`default_nettype none

module thsqd_pick #(
    parameter int NUM_WORKERS = thsqd_pkg::NUM_WORKERS_DEF,
    parameter int QUEUE_DEPTH = thsqd_pkg::QUEUE_DEPTH_DEF,
    localparam int WID_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic [CNT_W-1:0]                counts [NUM_WORKERS],
    input  wire logic [thsqd_pkg::THR_W-1:0]     threshold,
    input  wire logic [thsqd_pkg::ACTIVE_W-1:0]  active,
    output logic      [WID_W-1:0]                pick_idx
);

    localparam int CMP_W = (CNT_W > thsqd_pkg::THR_W) ? CNT_W : thsqd_pkg::THR_W;

    logic [NUM_WORKERS-1:0] act;
    logic [NUM_WORKERS-1:0] below;
    logic [NUM_WORKERS-1:0] first_below;
    logic [NUM_WORKERS-1:0] win;
    logic [WID_W-1:0]       below_idx;
    logic [WID_W-1:0]       min_idx;

    // active mask: worker 0 always, others below the active count
    always_comb begin
        for (int i = 0; i < NUM_WORKERS; i++) begin
            act[i]   = (i == 0) || (32'(active) > i);
            below[i] = act[i] && (CMP_W'(counts[i]) < CMP_W'(threshold));
        end
    end

    // the scan stops at the lowest active worker below threshold
    assign first_below = below & (~below + NUM_WORKERS'(1));

    // otherwise the shortest queue, lowest index on ties
    always_comb begin
        for (int i = 0; i < NUM_WORKERS; i++) begin
            win[i] = act[i];
            for (int j = 0; j < NUM_WORKERS; j++) begin
                if (act[j] && (j < i)) begin
                    win[i] = win[i] && (counts[i] < counts[j]);
                end else if (act[j] && (j > i)) begin
                    win[i] = win[i] && (counts[i] <= counts[j]);
                end
            end
        end
    end

    // one-hot to index
    always_comb begin
        below_idx = '0;
        min_idx   = '0;
        for (int i = 0; i < NUM_WORKERS; i++) begin
            if (first_below[i]) begin
                below_idx = below_idx | WID_W'(i);
            end
            if (win[i]) begin
                min_idx = min_idx | WID_W'(i);
            end
        end
    end

    assign pick_idx = (|below) ? below_idx : min_idx;

endmodule

`default_nettype wire

// File: rtl/threshold_shortest_queue_dispatcher_unit.sv
// Threshold shortest-queue dispatcher.
// Input channel s_*: one beat is a submit (s_op 0, job in s_task_id) or a
// take (s_op 1, worker in s_worker_sel). Every input beat gives exactly one
// result beat on m_*, in order: worker, job, status and the worker's new count.
// Configuration channel cfg_*: index 0 writes the threshold, index 1 the
// number of active workers; cfg_ready is always high. Write only when idle.
// A submit result is in the output register the cycle after acceptance;
// a take that finds a job first passes through the registered read of
// the job memory and then into the output register.
// Throughput: one submit per cycle while the receiver takes each result;
// a take that finds a job holds s_ready low until its read is done. A new
// beat is accepted in the same cycle as the previous result is taken.
// Worker choice comes from per-worker counts held in flops, compared
// combinationally.
// Reset clears all counts and pointers and loads threshold 2 and 8 active
// workers; the job memory is not cleared and needs no clearing pass.
// When the receiver stalls, the result is held in the output register and
// s_ready drops until it is taken.
`default_nettype none

`include "threshold_shortest_queue_dispatcher_unit_defines.svh"

module threshold_shortest_queue_dispatcher_unit #(
    parameter int NUM_WORKERS = thsqd_pkg::NUM_WORKERS_DEF,
    parameter int QUEUE_DEPTH = thsqd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [thsqd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [thsqd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic [thsqd_pkg::JOB_W-1:0]         s_task_id,
    input  wire logic [thsqd_pkg::WSEL_W-1:0]        s_worker_sel,
    // results
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [thsqd_pkg::WSEL_W-1:0]        m_worker_index,
    output logic      [thsqd_pkg::JOB_W-1:0]         m_job_id,
    output logic      [thsqd_pkg::STATUS_W-1:0]      m_status,
    output logic      [thsqd_pkg::PEND_W-1:0]        m_pending_after
);

    localparam int WID_W   = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH_ALL = NUM_WORKERS * QUEUE_DEPTH;
    localparam int ADDR_W  = (DEPTH_ALL > 1) ? $clog2(DEPTH_ALL) : 1;

    // configuration registers
    logic [thsqd_pkg::THR_W-1:0]    thr_reg;
    logic [thsqd_pkg::ACTIVE_W-1:0] active_reg;

    // per-worker queue state
    logic [CNT_W-1:0] cnt_reg  [NUM_WORKERS];
    logic [CNT_W-1:0] cnt_next [NUM_WORKERS];
    logic [PTR_W-1:0] head_reg  [NUM_WORKERS];
    logic [PTR_W-1:0] head_next [NUM_WORKERS];
    logic [PTR_W-1:0] tail_reg  [NUM_WORKERS];
    logic [PTR_W-1:0] tail_next [NUM_WORKERS];

    // output stage
    logic                               m_valid_reg;
    logic                               rd_pend_reg;
    logic [thsqd_pkg::WSEL_W-1:0]       m_worker_index_reg;
    logic [thsqd_pkg::JOB_W-1:0]        m_job_id_reg;
    logic [thsqd_pkg::STATUS_W-1:0]     m_status_reg;
    logic [thsqd_pkg::PEND_W-1:0]       m_pending_after_reg;

    logic              in_fire;
    logic              is_take;
    logic [WID_W-1:0]  pick_w;
    logic [WID_W-1:0]  sel_idx;
    logic              sel_ok;
    logic [CNT_W-1:0]  sub_cnt;
    logic [CNT_W-1:0]  sub_cnt_inc;
    logic              sub_full;
    logic [CNT_W-1:0]  tk_cnt;
    logic [CNT_W-1:0]  tk_cnt_dec;
    logic              tk_empty;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [thsqd_pkg::JOB_W-1:0] ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        ptr_adv = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= thsqd_pkg::THRESHOLD_RST;
            active_reg <= thsqd_pkg::ACTIVE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                thsqd_pkg::REG_THRESHOLD: thr_reg    <= cfg_data;
                thsqd_pkg::REG_ACTIVE:    active_reg <= cfg_data[thsqd_pkg::ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // worker choice for a submit
    thsqd_pick #(
        .NUM_WORKERS (NUM_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_pick (
        .counts    (cnt_reg),
        .threshold (thr_reg),
        .active    (active_reg),
        .pick_idx  (pick_w)
    );

    // handshake
    assign s_ready = !rd_pend_reg && (!m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;
    assign is_take = (s_op == thsqd_pkg::OP_TAKE);

    // queue lookups
    assign sel_ok      = 32'(s_worker_sel) < NUM_WORKERS;
    assign sel_idx     = WID_W'(s_worker_sel);
    assign sub_cnt     = cnt_reg[pick_w];
    assign sub_cnt_inc = sub_cnt + CNT_W'(1);
    assign sub_full    = (sub_cnt == CNT_W'(QUEUE_DEPTH));
    assign tk_cnt      = cnt_reg[sel_idx];
    assign tk_cnt_dec  = tk_cnt - CNT_W'(1);
    assign tk_empty    = !sel_ok || (tk_cnt == '0);

    assign ram_waddr = ADDR_W'(pick_w) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_reg[pick_w]);
    assign ram_raddr = ADDR_W'(sel_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_reg[sel_idx]);

    // pointer and count update, memory access
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        if (in_fire) begin
            if (!is_take) begin
                if (!sub_full) begin
                    ram_we            = 1'b1;
                    tail_next[pick_w] = ptr_adv(tail_reg[pick_w]);
                    cnt_next[pick_w]  = sub_cnt_inc;
                end
            end else if (!tk_empty) begin
                ram_re             = 1'b1;
                head_next[sel_idx] = ptr_adv(head_reg[sel_idx]);
                cnt_next[sel_idx]  = tk_cnt_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WORKERS; i++) begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // job memory
    thsqd_ram #(
        .WIDTH (thsqd_pkg::JOB_W),
        .DEPTH (DEPTH_ALL)
    ) u_job_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_task_id),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result valid and pending read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else if (rd_pend_reg) begin
            m_valid_reg <= 1'b1;
            rd_pend_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= !(is_take && !tk_empty);
            rd_pend_reg <= is_take && !tk_empty;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            m_job_id_reg <= ram_rdata;
        end else if (in_fire) begin
            if (!is_take) begin
                m_worker_index_reg  <= thsqd_pkg::WSEL_W'(pick_w);
                m_job_id_reg        <= s_task_id;
                m_status_reg        <= sub_full ? thsqd_pkg::ST_FULL : thsqd_pkg::ST_QUEUED;
                m_pending_after_reg <= sub_full ? thsqd_pkg::PEND_W'(sub_cnt)
                                                : thsqd_pkg::PEND_W'(sub_cnt_inc);
            end else begin
                m_worker_index_reg  <= s_worker_sel;
                m_job_id_reg        <= '0;
                m_status_reg        <= tk_empty ? thsqd_pkg::ST_EMPTY : thsqd_pkg::ST_TAKEN;
                m_pending_after_reg <= tk_empty ? '0 : thsqd_pkg::PEND_W'(tk_cnt_dec);
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_worker_index  = m_worker_index_reg;
    assign m_job_id        = m_job_id_reg;
    assign m_status        = m_status_reg;
    assign m_pending_after = m_pending_after_reg;

    // checks
    `THSQD_ASSERT_NEXT(a_read_done, rd_pend_reg, m_valid_reg && !rd_pend_reg, "take read not delivered")
    `THSQD_ASSERT_NEVER(a_slot_free, rd_pend_reg && m_valid_reg, "output busy during take read")
    `THSQD_ASSERT_NEXT(a_submit_res, in_fire && !is_take && !sub_full, m_valid_reg && (m_status_reg == thsqd_pkg::ST_QUEUED), "submit not queued")
    `THSQD_ASSERT_NEXT(a_empty_res, in_fire && is_take && tk_empty, m_valid_reg && (m_job_id_reg == '0) && (m_pending_after_reg == '0), "empty take result wrong")

endmodule

`default_nettype wire
